@@ hdl/fixed_point_pid_controller_macros.svh @@
// Assertion macros shared by the PID controller checker.
// Plain text only; the including file supplies the clock, reset and expressions.
`ifndef FIXED_POINT_PID_CONTROLLER_MACROS_SVH
`define FIXED_POINT_PID_CONTROLLER_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define PIDC_ASSERT_HOLD(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("pidc check failed: invariant");

// The consequent holds in the same cycle as the antecedent.
`define PIDC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pidc check failed: implication");

// The consequent holds in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pidc check failed: next-cycle implication");

`endif

@@ hdl/pidc_pkg.sv @@
// Shared types, constants and elaboration helpers of the PID controller.
// No dependencies; every other file but the macros header imports this package.
package pidc_pkg;

  // Width of the wide signed datapath words (products and the output sum).
  localparam int PIDC_DW = 34;

  // Fraction bits of the Q12 derivative feedback coefficient.
  localparam int PIDC_POLE_FRAC = 12;

  // Scale between centi-units and units.
  localparam int PIDC_CENTI = 100;

  typedef enum logic {
    PIDC_CMD_UPDATE = 1'b0,
    PIDC_CMD_CLEAR  = 1'b1
  } pidc_cmd_e;

  typedef enum logic [3:0] {
    PIDC_REG_PROP_GAIN     = 4'd0,
    PIDC_REG_INTEG_GAIN    = 4'd1,
    PIDC_REG_DERIV_POLE    = 4'd2,
    PIDC_REG_DERIV_GAIN    = 4'd3,
    PIDC_REG_DRIVE_FLOOR   = 4'd4,
    PIDC_REG_DRIVE_CEILING = 4'd5,
    PIDC_REG_INTEG_FLOOR   = 4'd6,
    PIDC_REG_INTEG_CEILING = 4'd7
  } pidc_reg_e;

  // Index of the lowest set bit, used to split a divisor into a power of two
  // and an odd factor at elaboration.
  function automatic int pidc_ctz(input int unsigned v);
    int n;
    n = 0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        n = i;
      end
    end
    return n;
  endfunction

endpackage

@@ hdl/fixed_point_pid_controller.sv @@
// Top level of the fixed-point PID controller: configuration, state loop and output stage.
// Depends on pidc_pkg and instantiates pidc_cdiv for all constant divisions.
//
//   Channel   Handshake                  Payload
//   -------   ------------------------   -----------------------------------
//   input     in_valid_i / in_ready_o    cmd_i, target_i, measured_i
//   output    out_valid_o / out_ready_i  drive_o
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One transaction can enter every cycle while the skid register is empty.
// A control update reaches its drive result through the constant dividers
// (two stages each) and the output register. The rate is set by the state
// loop stage, which closes the integrator and derivative recurrences in its own registers.
// Reset is asynchronous and needs no clearing pass. A stalled output fills a
// skid register, and only then is the input held off.
module fixed_point_pid_controller #(
  parameter int INTEG_DIVISOR = 83200
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  pidc_pkg::pidc_cmd_e      cmd_i,
  input  logic signed [15:0]       target_i,
  input  logic signed [15:0]       measured_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [15:0]       drive_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [3:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i
);
  import pidc_pkg::*;

  localparam int DW    = PIDC_DW;
  // The carry stays strictly inside the divisor, so it needs the divisor's
  // magnitude bits plus a sign.
  localparam int REM_W = $clog2(INTEG_DIVISOR) + 1;
  localparam int SW    = REM_W + 2;
  localparam int SUMW  = DW + 1;
  localparam int PDW   = 14 + 32;
  localparam int DNW   = DW + 2;

  localparam logic signed [SW-1:0]  D_S     = SW'(INTEG_DIVISOR);
  localparam logic signed [SW-1:0]  NEG_D_S = -D_S;
  localparam logic signed [SW-1:0]  D2_S    = D_S + D_S;
  localparam logic signed [PDW-1:0] POLE_RND = PDW'((1 << PIDC_POLE_FRAC) - 1);
  localparam logic signed [31:0]    S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0]    S32_MAX = 32'sh7fff_ffff;

  // ------------------------------------------------------------------
  // Configuration registers. Writes are taken at any time; the user only
  // writes while the controller is idle.
  // ------------------------------------------------------------------
  logic [15:0]        prop_gain_q;
  logic [15:0]        integ_gain_q;
  logic signed [13:0] deriv_pole_q;
  logic signed [15:0] deriv_gain_q;
  logic signed [15:0] drive_floor_q;
  logic signed [15:0] drive_ceiling_q;
  logic signed [31:0] integ_floor_q;
  logic signed [31:0] integ_ceiling_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     <= '0;
      integ_gain_q    <= '0;
      deriv_pole_q    <= '0;
      deriv_gain_q    <= '0;
      drive_floor_q   <= 16'sh8000;
      drive_ceiling_q <= 16'sh7fff;
      integ_floor_q   <= S32_MIN;
      integ_ceiling_q <= S32_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pidc_reg_e'(cfg_index_i))
        PIDC_REG_PROP_GAIN:     prop_gain_q     <= cfg_data_i[15:0];
        PIDC_REG_INTEG_GAIN:    integ_gain_q    <= cfg_data_i[15:0];
        PIDC_REG_DERIV_POLE:    deriv_pole_q    <= cfg_data_i[13:0];
        PIDC_REG_DERIV_GAIN:    deriv_gain_q    <= cfg_data_i[15:0];
        PIDC_REG_DRIVE_FLOOR:   drive_floor_q   <= cfg_data_i[15:0];
        PIDC_REG_DRIVE_CEILING: drive_ceiling_q <= cfg_data_i[15:0];
        PIDC_REG_INTEG_FLOOR:   integ_floor_q   <= cfg_data_i;
        PIDC_REG_INTEG_CEILING: integ_ceiling_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Pipeline enable. The whole pipeline moves together and only freezes
  // when the skid register is occupied, which happens only while a result
  // is already waiting on the output.
  // ------------------------------------------------------------------
  logic skid_v_q;
  logic en;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // ------------------------------------------------------------------
  // Stage 1: input register. The error is formed on the way in, and the
  // previous error is tracked in arrival order so that a clear command
  // zeroes it for the next update.
  // ------------------------------------------------------------------
  logic signed [16:0] err_in;
  logic signed [16:0] last_err_q;
  logic               v1_q;
  logic               clr1_q;
  logic signed [16:0] e1_q;
  logic signed [16:0] le1_q;

  assign err_in = 17'(target_i) - 17'(measured_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else if (en && in_valid_i) begin
      last_err_q <= (cmd_i == PIDC_CMD_CLEAR) ? '0 : err_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      clr1_q <= (cmd_i == PIDC_CMD_CLEAR);
      e1_q   <= err_in;
      le1_q  <= last_err_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: the three gain products. None of them depends on loop state.
  // ------------------------------------------------------------------
  logic signed [17:0]   esum1;
  logic signed [17:0]   ediff1;
  logic signed [DW-1:0] pe_d;
  logic signed [DW-1:0] ip_d;
  logic signed [DW-1:0] dp_d;
  logic                 v2_q;
  logic                 clr2_q;
  logic signed [DW-1:0] pe2_q;
  logic signed [DW-1:0] ip2_q;
  logic signed [DW-1:0] dp2_q;

  assign esum1  = 18'(e1_q) + 18'(le1_q);
  assign ediff1 = 18'(e1_q) - 18'(le1_q);
  assign pe_d   = DW'(signed'({1'b0, prop_gain_q})) * DW'(e1_q);
  assign ip_d   = DW'(signed'({1'b0, integ_gain_q})) * DW'(esum1);
  assign dp_d   = DW'(deriv_gain_q) * DW'(ediff1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      clr2_q <= clr1_q;
      pe2_q  <= pe_d;
      ip2_q  <= ip_d;
      dp2_q  <= dp_d;
    end
  end

  // ------------------------------------------------------------------
  // Stages 3 and 4: constant divisions of the products. The integrator
  // product is split into quotient and remainder by the carry divisor.
  // ------------------------------------------------------------------
  logic signed [DW-1:0] p4;
  logic signed [DW-1:0] p4_rem;
  logic signed [DW-1:0] dq4;
  logic signed [DW-1:0] dq4_rem;
  logic signed [DW-1:0] iquo4;
  logic signed [DW-1:0] irem4;
  logic                 v3_q;
  logic                 clr3_q;
  logic                 v4_q;
  logic                 clr4_q;

  pidc_cdiv #(.WIDTH(DW), .DIVISOR(PIDC_CENTI)) u_pdiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (pe2_q),
    .quo_o (p4),
    .rem_o (p4_rem)
  );

  pidc_cdiv #(.WIDTH(DW), .DIVISOR(PIDC_CENTI)) u_ddiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (dp2_q),
    .quo_o (dq4),
    .rem_o (dq4_rem)
  );

  pidc_cdiv #(.WIDTH(DW), .DIVISOR(INTEG_DIVISOR)) u_idiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ip2_q),
    .quo_o (iquo4),
    .rem_o (irem4)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      clr3_q <= clr2_q;
      clr4_q <= clr3_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: the state loop. The new carry is the old carry plus the
  // product's remainder; since both lie strictly inside the divisor, the
  // quotient correction is at most two steps of floor normalization
  // followed by the fix-up that turns floor division into truncation.
  // ------------------------------------------------------------------
  logic signed [REM_W-1:0] rp4;
  logic signed [SW-1:0]    s_sum;
  logic signed [SW-1:0]    rf;
  logic signed [2:0]       qa;
  logic signed [DW-1:0]    qf;
  logic                    trunc_fix;
  logic signed [DW-1:0]    q_int;
  logic signed [SW-1:0]    r_int;
  logic signed [SUMW-1:0]  sum_ext;
  logic signed [SUMW-1:0]  ifloor_ext;
  logic signed [SUMW-1:0]  iceil_ext;
  logic signed [31:0]      integ_sum_d;
  logic signed [REM_W-1:0] integ_rem_d;
  logic signed [PDW-1:0]   pd;
  logic signed [PDW-1:0]   pd_adj;
  logic signed [PDW-1:0]   pd_sh;
  logic signed [DNW-1:0]   pd_tr;
  logic signed [DNW-1:0]   dsum;
  logic signed [31:0]      deriv_d;
  logic signed [31:0]      integ_sum_q;
  logic signed [REM_W-1:0] integ_rem_q;
  logic signed [31:0]      deriv_q;
  logic                    rv5_q;
  logic signed [DW-1:0]    p5_q;

  assign rp4 = irem4[REM_W-1:0];

  always_comb begin
    s_sum = SW'(integ_rem_q) + SW'(rp4);
    if (s_sum >= D_S) begin
      qa = 3'sd1;
      rf = s_sum - D_S;
    end else if (!s_sum[SW-1]) begin
      qa = 3'sd0;
      rf = s_sum;
    end else if (s_sum >= NEG_D_S) begin
      qa = -3'sd1;
      rf = s_sum + D_S;
    end else begin
      qa = -3'sd2;
      rf = s_sum + D2_S;
    end
    qf        = iquo4 + DW'(qa);
    // A negative dividend with a nonzero remainder rounds toward zero.
    trunc_fix = qf[DW-1] && (rf != '0);
    q_int     = trunc_fix ? (qf + DW'(1)) : qf;
    r_int     = trunc_fix ? (rf - D_S) : rf;

    sum_ext    = SUMW'(integ_sum_q) + SUMW'(q_int);
    ifloor_ext = SUMW'(integ_floor_q);
    iceil_ext  = SUMW'(integ_ceiling_q);
    if (sum_ext < ifloor_ext) begin
      integ_sum_d = integ_floor_q;
    end else if (sum_ext > iceil_ext) begin
      integ_sum_d = integ_ceiling_q;
    end else begin
      integ_sum_d = sum_ext[31:0];
    end
    integ_rem_d = r_int[REM_W-1:0];
  end

  // Derivative filter: pole * previous value / 4096, truncated toward zero,
  // plus the precomputed error-change term, then saturated to 32 bits.
  assign pd     = PDW'(deriv_pole_q) * PDW'(deriv_q);
  assign pd_adj = pd + (pd[PDW-1] ? POLE_RND : '0);
  assign pd_sh  = pd_adj >>> PIDC_POLE_FRAC;
  assign pd_tr  = pd_sh[DNW-1:0];
  assign dsum   = pd_tr + DNW'(dq4);

  always_comb begin
    if (dsum < DNW'(S32_MIN)) begin
      deriv_d = S32_MIN;
    end else if (dsum > DNW'(S32_MAX)) begin
      deriv_d = S32_MAX;
    end else begin
      deriv_d = dsum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_sum_q <= '0;
      integ_rem_q <= '0;
      deriv_q     <= '0;
    end else if (en && v4_q) begin
      if (clr4_q) begin
        integ_sum_q <= '0;
        integ_rem_q <= '0;
        deriv_q     <= '0;
      end else begin
        // A zero integral gain freezes both the sum and the carry.
        if (integ_gain_q != '0) begin
          integ_sum_q <= integ_sum_d;
          integ_rem_q <= integ_rem_d;
        end
        deriv_q <= deriv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_q <= p4;
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: the output sum, read from the state just written by this item.
  // Stages 7 and 8: division by 100.
  // ------------------------------------------------------------------
  logic signed [DW-1:0] total6_q;
  logic signed [DW-1:0] quo8;
  logic signed [DW-1:0] quo8_rem;
  logic                 rv6_q;
  logic                 rv7_q;
  logic                 rv8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      total6_q <= p5_q + DW'(integ_sum_q) + DW'(deriv_q);
    end
  end

  pidc_cdiv #(.WIDTH(DW), .DIVISOR(PIDC_CENTI)) u_tdiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (total6_q),
    .quo_o (quo8),
    .rem_o (quo8_rem)
  );

  // Valid bits of every stage. Clear commands stop producing a result at
  // the loop stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      rv5_q <= 1'b0;
      rv6_q <= 1'b0;
      rv7_q <= 1'b0;
      rv8_q <= 1'b0;
    end else if (en) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      rv5_q <= v4_q && !clr4_q;
      rv6_q <= rv5_q;
      rv7_q <= rv6_q;
      rv8_q <= rv7_q;
    end
  end

  // ------------------------------------------------------------------
  // Output clamp, output register and skid register.
  // ------------------------------------------------------------------
  logic signed [15:0] res;
  logic               out_v_q;
  logic signed [15:0] out_q;
  logic signed [15:0] skid_q;
  logic               out_load;
  logic               skid_load;
  logic               skid_drain;

  always_comb begin
    if (quo8 < DW'(drive_floor_q)) begin
      res = drive_floor_q;
    end else if (quo8 > DW'(drive_ceiling_q)) begin
      res = drive_ceiling_q;
    end else begin
      res = quo8[15:0];
    end
  end

  assign out_load   = en && (!out_v_q || out_ready_i);
  assign skid_load  = en && out_v_q && !out_ready_i && rv8_q;
  assign skid_drain = !en && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_q <= rv8_q;
      end
      if (skid_load) begin
        skid_v_q <= 1'b1;
      end else if (skid_drain) begin
        skid_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end else if (skid_drain) begin
      out_q <= skid_q;
    end
    if (skid_load) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign drive_o     = out_q;

endmodule

@@ hdl/pidc_cdiv.sv @@
// Two-stage signed division by a constant, truncating toward zero, with remainder.
// Depends on pidc_pkg for the divisor factoring helper.
module pidc_cdiv #(
  parameter int WIDTH   = 34,
  parameter int DIVISOR = 100
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WIDTH-1:0] num_i,
  output logic signed [WIDTH-1:0] quo_o,
  output logic signed [WIDTH-1:0] rem_o
);
  import pidc_pkg::*;

  // The divisor is 2^SHIFT * ODD; the odd part is handled by an exact
  // reciprocal multiply on the magnitude shifted right by SHIFT.
  localparam int SHIFT = pidc_ctz(DIVISOR);
  localparam int ODD   = DIVISOR >> SHIFT;
  localparam int N     = WIDTH - SHIFT;
  localparam int K     = N + $clog2(ODD);
  localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'(ODD) - 64'd1) / 64'(ODD);
  localparam logic [K:0] RECIP = RECIP64[K:0];
  localparam logic [WIDTH-1:0] DIV_W = WIDTH'(DIVISOR);

  logic             neg;
  logic [WIDTH-1:0] mag;
  logic [N-1:0]     scaled;
  logic [N+K:0]     prod_d;
  logic [N+K:0]     prod_q;
  logic             neg_q;
  logic [WIDTH-1:0] mag_q;
  logic [N-1:0]     qmag;
  logic [WIDTH-1:0] rmag;
  logic [WIDTH-1:0] quo_q;
  logic [WIDTH-1:0] rem_q;

  assign neg    = num_i[WIDTH-1];
  assign mag    = neg ? ('0 - unsigned'(num_i)) : unsigned'(num_i);
  assign scaled = mag[WIDTH-1:SHIFT];
  assign prod_d = (N+K+1)'(scaled) * RECIP;

  assign qmag = prod_q[K +: N];
  assign rmag = mag_q - WIDTH'(qmag) * DIV_W;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      neg_q  <= neg;
      mag_q  <= mag;
      quo_q  <= neg_q ? ('0 - WIDTH'(qmag)) : WIDTH'(qmag);
      rem_q  <= neg_q ? ('0 - rmag) : rmag;
    end
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;

endmodule

@@ hdl/pidc_checker.sv @@
// Port-level checker of the PID controller, attached to the top level by a bind.
// Depends on pidc_pkg and the assertion macros header.
`include "fixed_point_pid_controller_macros.svh"

module pidc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input pidc_pkg::pidc_cmd_e cmd_i,
  input logic signed [15:0]  target_i,
  input logic signed [15:0]  measured_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic signed [15:0]  drive_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [3:0]          cfg_index_i,
  input logic [31:0]         cfg_data_i
);
  import pidc_pkg::*;

  // Eight pipeline stages plus the output and skid registers.
  localparam logic [4:0] INFLIGHT_MAX = 5'd10;

  logic       upd_in;
  logic       res_out;
  logic [4:0] pend_q;
  logic [4:0] pend_d;

  assign upd_in  = in_valid_i && in_ready_o && (cmd_i == PIDC_CMD_UPDATE);
  assign res_out = out_valid_o && out_ready_i;
  assign pend_d  = pend_q + 5'(upd_in) - 5'(res_out);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A waiting result keeps its value until it is taken.
  `PIDC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(drive_o))

  // With nothing on the output, the skid register is empty and input is open.
  `PIDC_ASSERT_IMPL(a_ready_when_drained, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // Every result belongs to an accepted update; clears never produce one.
  `PIDC_ASSERT_IMPL(a_no_extra_result, clk_i, rst_ni, out_valid_o, pend_q != 5'd0)

  // Updates in flight never exceed the storage of the pipeline.
  `PIDC_ASSERT_HOLD(a_inflight_bound, clk_i, rst_ni, pend_q <= INFLIGHT_MAX)

endmodule

bind fixed_point_pid_controller pidc_checker u_pidc_checker (.*);

@@ tb/fixed_point_pid_controller_tb.sv @@
// Self-checking testbench of the fixed-point PID controller.
// Depends on pidc_pkg and fixed_point_pid_controller; needs no files or arguments.
module fixed_point_pid_controller_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import pidc_pkg::*;

  localparam int ClkHalf = 10;
  localparam int ResetCycles = 12;
  localparam longint IntegDivisor = 83200;
  // Idle wait before touching the registers, so that a trailing clear has
  // surely gone through the data path.
  localparam int SettleCycles = 16;
  localparam int DrainLimit = 4000;
  localparam int TimeoutCycles = 200000;
  localparam int SegmentCount = 12;
  localparam int SegmentItems = 33;
  localparam int MaxPrinted = 40;

  localparam longint Int32Min = -64'sd2147483648;
  localparam longint Int32Max = 64'sd2147483647;
  localparam logic signed [31:0] IntegLowReset = 32'sh8000_0000;
  localparam logic signed [31:0] IntegHighReset = 32'sh7fff_ffff;

  // One complete register setting, in the order of the register indexes.
  typedef struct packed {
    logic [15:0]        kp;
    logic [15:0]        ki;
    logic signed [13:0] pole;
    logic signed [15:0] kd;
    logic signed [15:0] dlo;
    logic signed [15:0] dhi;
    logic signed [31:0] ilo;
    logic signed [31:0] ihi;
  } pid_cfg_t;

  // One row of the directed stimulus. A row with a preset first drains the
  // pipeline and loads that setting. A row with check set carries a drive
  // value that is obvious from the arithmetic; the rest use the predictor.
  typedef struct packed {
    logic signed [7:0]  preset;
    pidc_cmd_e          cmd;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    logic               check;
    logic signed [15:0] drive;
  } stim_row_t;

  localparam logic signed [7:0] NoCfg = -8'sd1;

  // Setting 0: full gains and unit pole, to drive every term to its extreme.
  // Setting 1: pure proportional with crossed drive limits (floor 100, ceiling
  //            -100), so the floor test must win below 100 and the ceiling otherwise.
  // Setting 2: crossed integrator limits and a positive pole beyond one.
  // Setting 3: integrator frozen, pole of minus two, to saturate the filter.
  localparam pid_cfg_t Presets [4] = '{
    '{16'd65535, 16'd65535, 14'sd4096, 16'sd32767, -16'sd32768, 16'sd32767,
      IntegLowReset, IntegHighReset},
    '{16'd100, 16'd0, 14'sd0, 16'sd0, 16'sd100, -16'sd100,
      IntegLowReset, IntegHighReset},
    '{16'd0, 16'd65535, 14'sd8191, -16'sd32768, -16'sd32768, 16'sd32767,
      32'sd5, -32'sd5},
    '{16'd0, 16'd0, -14'sd8192, 16'sd32767, -16'sd32768, 16'sd32767,
      IntegLowReset, IntegHighReset}
  };

  localparam int DirCount = 24;
  localparam stim_row_t DirRows [DirCount] = '{
    // Straight after reset every gain is zero, so the drive is zero.
    '{NoCfg, PIDC_CMD_UPDATE, 16'sd0, 16'sd0, 1'b1, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, 16'sd32767, -16'sd32768, 1'b1, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, -16'sd32768, 16'sd32767, 1'b1, 16'sd0},
    '{NoCfg, PIDC_CMD_CLEAR, 16'sd1234, -16'sd1234, 1'b0, 16'sd0},
    // Largest error either way with full gains hits the drive rails.
    '{8'sd0, PIDC_CMD_UPDATE, 16'sd32767, -16'sd32768, 1'b1, 16'sd32767},
    '{NoCfg, PIDC_CMD_UPDATE, -16'sd32768, 16'sd32767, 1'b1, -16'sd32768},
    '{NoCfg, PIDC_CMD_UPDATE, 16'sd150, 16'sd0, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, 16'sd150, 16'sd0, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, -16'sd7, 16'sd93, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_CLEAR, 16'sd0, 16'sd0, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, 16'sd1, 16'sd0, 1'b0, 16'sd0},
    // Crossed drive limits: the result is always one of the two limits.
    '{8'sd1, PIDC_CMD_UPDATE, 16'sd0, 16'sd0, 1'b1, 16'sd100},
    '{NoCfg, PIDC_CMD_UPDATE, 16'sd20000, 16'sd0, 1'b1, -16'sd100},
    '{NoCfg, PIDC_CMD_UPDATE, -16'sd32768, 16'sd32767, 1'b1, 16'sd100},
    // Crossed integrator limits and an out-of-range pole.
    '{8'sd2, PIDC_CMD_UPDATE, 16'sd32767, -16'sd32768, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, -16'sd32768, 16'sd32767, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, 16'sd0, 16'sd0, 1'b0, 16'sd0},
    // Alternating full-scale error with a pole of minus two roughly doubles
    // the filter state each step until it saturates at the 32-bit rails.
    '{8'sd3, PIDC_CMD_UPDATE, 16'sd32767, -16'sd32768, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, -16'sd32768, 16'sd32767, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, 16'sd32767, -16'sd32768, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, -16'sd32768, 16'sd32767, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, 16'sd32767, -16'sd32768, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, -16'sd32768, 16'sd32767, 1'b0, 16'sd0},
    '{NoCfg, PIDC_CMD_UPDATE, 16'sd32767, -16'sd32768, 1'b0, 16'sd0}
  };

  // Every input starts at a known value; reset is held low from time zero.
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  pidc_cmd_e         cmd_i = PIDC_CMD_UPDATE;
  logic signed [15:0] target_i = '0;
  logic signed [15:0] measured_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic signed [15:0] drive_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [3:0]        cfg_index_i = '0;
  logic [31:0]       cfg_data_i = '0;

  // Idle rates of the two channels, in percent of cycles.
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int mismatch_count = 0;

  // Drive values owed by the block, oldest first.
  logic signed [15:0] pending_drives [$];

  // The predictor's copy of the registers and the controller state, at the
  // widths the block keeps them.
  logic [15:0]        kp_r, ki_r;
  logic signed [13:0] pole_r;
  logic signed [15:0] kd_r, dlo_r, dhi_r;
  logic signed [31:0] ilo_r, ihi_r;
  logic signed [31:0] integ_acc;
  logic signed [17:0] integ_carry;
  logic signed [16:0] prev_err;
  logic signed [31:0] deriv_acc;

  fixed_point_pid_controller #(
    .INTEG_DIVISOR(83200)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .target_i    (target_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // The run may never hang; a run that gets this far has failed.
  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("FAIL fixed_point_pid_controller");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxPrinted) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic longint clamp_wide(input longint v, input longint lo, input longint hi);
    // The floor is tested first, so crossed limits give one of the two.
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic void zero_pid_state();
    integ_acc = '0;
    integ_carry = '0;
    prev_err = '0;
    deriv_acc = '0;
  endfunction

  function automatic void store_reg(input logic [3:0] idx, input logic [31:0] data);
    case (idx)
      PIDC_REG_PROP_GAIN:     kp_r = data[15:0];
      PIDC_REG_INTEG_GAIN:    ki_r = data[15:0];
      PIDC_REG_DERIV_POLE:    pole_r = data[13:0];
      PIDC_REG_DERIV_GAIN:    kd_r = data[15:0];
      PIDC_REG_DRIVE_FLOOR:   dlo_r = data[15:0];
      PIDC_REG_DRIVE_CEILING: dhi_r = data[15:0];
      PIDC_REG_INTEG_FLOOR:   ilo_r = data;
      PIDC_REG_INTEG_CEILING: ihi_r = data;
      default: ;
    endcase
  endfunction

  // Advances the controller by one update and returns the drive it owes.
  // All arithmetic is 64-bit signed: SystemVerilog division truncates toward
  // zero and the remainder follows the dividend, as the block requires.
  function automatic logic signed [15:0] advance_pid(input logic signed [15:0] tgt,
                                                     input logic signed [15:0] meas);
    longint err, prop, carry, filt, total;
    err = longint'(tgt) - longint'(meas);
    prop = longint'(kp_r) * err / 100;
    // A zero integral gain freezes both the sum and its carry.
    if (ki_r != 16'd0) begin
      carry = longint'(integ_carry) + longint'(ki_r) * (err + longint'(prev_err));
      integ_acc = 32'(clamp_wide(longint'(integ_acc) + carry / IntegDivisor,
                                 longint'(ilo_r), longint'(ihi_r)));
      integ_carry = 18'(carry % IntegDivisor);
    end
    filt = longint'(pole_r) * longint'(deriv_acc) / 4096
         + longint'(kd_r) * (err - longint'(prev_err)) / 100;
    deriv_acc = 32'(clamp_wide(filt, Int32Min, Int32Max));
    prev_err = 17'(err);
    total = prop + longint'(integ_acc) + longint'(deriv_acc);
    return 16'(clamp_wide(total / 100, longint'(dlo_r), longint'(dhi_r)));
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Angles: mostly mid-range or near the setpoint, with the rails mixed in.
  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 9))
      0:       return 16'sd32767;
      1:       return -16'sd32768;
      2, 3, 4: return 16'($urandom);
      default: return 16'(span(-2000, 2000));
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'd65535;
      2:       return 16'($urandom_range(0, 500));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pid_cfg_t rand_cfg();
    pid_cfg_t c;
    int a;
    c.kp = rand_gain();
    c.ki = rand_gain();
    case ($urandom_range(0, 4))
      0:       c.pole = 14'sd4096;
      1:       c.pole = -14'sd4096;
      2:       c.pole = 14'(span(-4096, 4096));
      3:       c.pole = 14'($urandom);
      default: c.pole = '0;
    endcase
    case ($urandom_range(0, 3))
      0:       c.kd = 16'sd32767;
      1:       c.kd = -16'sd32768;
      2:       c.kd = 16'(span(-300, 300));
      default: c.kd = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: begin
        c.dlo = -16'sd32768;
        c.dhi = 16'sd32767;
      end
      1: begin
        a = span(-3000, 3000);
        c.dlo = 16'(a);
        c.dhi = 16'(span(a, 3000));
      end
      2: begin
        c.dlo = 16'($urandom);
        c.dhi = 16'($urandom);
      end
      default: begin
        c.dlo = 16'(span(-500, 500));
        c.dhi = c.dlo;
      end
    endcase
    case ($urandom_range(0, 3))
      0: begin
        c.ilo = IntegLowReset;
        c.ihi = IntegHighReset;
      end
      1: begin
        c.ilo = 32'(span(-200000, 0));
        c.ihi = 32'(span(0, 200000));
      end
      2: begin
        c.ilo = $urandom;
        c.ihi = $urandom;
      end
      default: begin
        c.ilo = 32'(span(1, 5000));
        c.ihi = -c.ilo;
      end
    endcase
    return c;
  endfunction

  // Leaves cfg_valid_i high so that back-to-back writes never lower and raise
  // it within one time step; the caller lowers it after the last write.
  task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    store_reg(idx, data);
  endtask

  // Writes a whole setting. The unused upper data bits carry noise, and one
  // write to an unassigned index checks that such writes change nothing.
  task automatic apply_cfg(input pid_cfg_t c);
    write_reg(PIDC_REG_PROP_GAIN, {16'($urandom), c.kp});
    write_reg(PIDC_REG_INTEG_GAIN, {16'($urandom), c.ki});
    write_reg(PIDC_REG_DERIV_POLE, {18'($urandom), c.pole});
    write_reg(4'(PIDC_REG_INTEG_CEILING) + 4'($urandom_range(1, 8)), $urandom);
    write_reg(PIDC_REG_DERIV_GAIN, {16'($urandom), c.kd});
    write_reg(PIDC_REG_DRIVE_FLOOR, {16'($urandom), c.dlo});
    write_reg(PIDC_REG_DRIVE_CEILING, {16'($urandom), c.dhi});
    write_reg(PIDC_REG_INTEG_FLOOR, c.ilo);
    write_reg(PIDC_REG_INTEG_CEILING, c.ihi);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one input transaction and books the drive it should produce. The
  // predictor runs at the edge of acceptance, well ahead of the result.
  // Like write_reg, it leaves in_valid_i high after acceptance.
  task automatic send_sample(input pidc_cmd_e cmd, input logic signed [15:0] tgt,
                             input logic signed [15:0] meas, input logic check,
                             input logic signed [15:0] drive);
    logic signed [15:0] predicted;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    target_i <= tgt;
    measured_i <= meas;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == PIDC_CMD_CLEAR) begin
      zero_pid_state();
    end else begin
      predicted = advance_pid(tgt, meas);
      pending_drives.push_back(check ? drive : predicted);
    end
  endtask

  // Waits until every owed drive has arrived, then lets the pipeline run
  // empty so that a trailing clear is done before registers change.
  task automatic settle_outputs();
    int waited;
    waited = 0;
    while (pending_drives.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_drives.size() != 0) begin
      report_mismatch($sformatf("%0d drive results never arrived", pending_drives.size()));
      pending_drives.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The receiver stalls at random; with a zero rate it is always ready.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Every output transaction must match the oldest owed drive.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_drives.size() == 0) begin
        report_mismatch($sformatf("unexpected drive %0d", drive_o));
      end else if (drive_o !== pending_drives[0]) begin
        report_mismatch($sformatf("drive %0d, predicted %0d", drive_o, pending_drives[0]));
        void'(pending_drives.pop_front());
      end else begin
        void'(pending_drives.pop_front());
      end
    end
  end

  initial begin
    pid_cfg_t seg_cfg;
    pidc_cmd_e seg_cmd;
    kp_r = '0;
    ki_r = '0;
    pole_r = '0;
    kd_r = '0;
    dlo_r = -16'sd32768;
    dhi_r = 16'sd32767;
    ilo_r = IntegLowReset;
    ihi_r = IntegHighReset;
    zero_pid_state();

    // First phase: the sender is mostly busy, the receiver mostly stalled.
    in_idle_pct = 32;
    out_stall_pct = 82;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      if (DirRows[i].preset != NoCfg) begin
        in_valid_i <= 1'b0;
        settle_outputs();
        apply_cfg(Presets[int'(DirRows[i].preset)]);
      end
      send_sample(DirRows[i].cmd, DirRows[i].tgt, DirRows[i].meas,
                  DirRows[i].check, DirRows[i].drive);
    end

    // Random part: each segment gets a fresh setting. The idle rates swap
    // after a third of the segments and drop to zero for the last third.
    for (int seg = 0; seg < SegmentCount; seg++) begin
      in_valid_i <= 1'b0;
      settle_outputs();
      if (seg == SegmentCount / 3) begin
        in_idle_pct = 82;
        out_stall_pct = 32;
      end else if (seg == 2 * SegmentCount / 3) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      seg_cfg = rand_cfg();
      apply_cfg(seg_cfg);
      repeat (SegmentItems) begin
        seg_cmd = ($urandom_range(0, 24) == 0) ? PIDC_CMD_CLEAR : PIDC_CMD_UPDATE;
        send_sample(seg_cmd, rand_angle(), rand_angle(), 1'b0, 16'sd0);
      end
    end

    in_valid_i <= 1'b0;
    settle_outputs();
    if (mismatch_count == 0) begin
      $display("PASS fixed_point_pid_controller");
    end else begin
      $display("FAIL fixed_point_pid_controller");
    end
    $finish;
  end

endmodule
